// ===== hdl/mexp_pkg.sv =====
// package for the modular exponentiation unit: word width, register indexes, states
// no dependencies
`default_nettype none
package mexp_pkg;
  localparam int WordBits = 32;
  localparam int CntBits  = $clog2(WordBits);
  typedef logic [WordBits-1:0] word_t;
  typedef logic [CntBits-1:0]  cnt_t;

  localparam logic RegModulus  = 1'b0;
  localparam logic RegExponent = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REDUCE, ST_SQUARE, ST_MULT, ST_DONE
  } state_t;

  // launch control of the shared modular multiplier
  typedef struct packed {
    logic start;   // load operands
    logic bypass;  // modulus zero: wrap to word width
  } mm_ctrl_t;
endpackage
`default_nettype wire

// ===== hdl/mexp_cell.sv =====
// one bit cell of the modular doubling and addition chain
// depends on mexp_pkg
`default_nettype none
module mexp_cell
  import mexp_pkg::*;
(
  input  wire logic r_in,
  input  wire logic a_in,
  input  wire logic m_in,
  input  wire logic c_in,  // carry of r+a (sum chain)
  input  wire logic b_in,  // borrow of sum-m chain
  output logic      s,
  output logic      c_out,
  output logic      d,
  output logic      b_out
);
  // full add of the partial value and the addend
  assign s     = r_in ^ a_in ^ c_in;
  assign c_out = (r_in & a_in) | (c_in & (r_in ^ a_in));
  // full subtract of the modulus
  assign d     = s ^ m_in ^ b_in;
  assign b_out = (~s & m_in) | (~(s ^ m_in) & b_in);
endmodule
`default_nettype wire

// ===== hdl/mexp_mulmod.sv =====
// bit-serial modular multiplier built from a row of cells, one multiplier bit a step
// depends on mexp_pkg and mexp_cell
`default_nettype none
module mexp_mulmod
  import mexp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mm_ctrl_t ctrl,
  input  wire word_t    a,
  input  wire word_t    b,
  input  wire word_t    m,
  output logic          busy,
  output logic          done,
  output word_t         p
);
  word_t        r, r_next, bq;
  logic [WordBits:0] rdbl;
  cnt_t         cnt;
  logic         bypass;
  logic [2*WordBits-1:0] wide;

  // step 1: r = 2r mod m; step 2 (next phase): add a when bit set, via cells
  // split into two half-steps using a phase bit to keep one add and compare per cycle
  logic phase;
  word_t addend;
  logic [WordBits:0] carry, borrow;
  logic [WordBits:0] sum_w, dif_w;
  word_t r_src;

  assign r_src  = r;
  assign addend = phase ? (bq[WordBits-1] ? a : '0) : r;
  assign carry[0]  = 1'b0;
  assign borrow[0] = 1'b0;
  genvar i;
  generate
    for (i = 0; i < WordBits; i++) begin : g_row
      mexp_cell u_cell (
        .r_in(r_src[i]), .a_in(addend[i]), .m_in(m[i]),
        .c_in(carry[i]), .b_in(borrow[i]),
        .s(sum_w[i]), .c_out(carry[i+1]), .d(dif_w[i]), .b_out(borrow[i+1])
      );
    end
  endgenerate
  assign sum_w[WordBits] = carry[WordBits];
  assign dif_w[WordBits] = 1'b0;
  // reduce: subtract when sum is not below m
  assign rdbl   = {1'b0, sum_w[WordBits-1:0]};
  assign r_next = (carry[WordBits] || !borrow[WordBits]) ? dif_w[WordBits-1:0]
                                                         : sum_w[WordBits-1:0];
  assign wide = a * b;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy   <= 1'b1;
        bypass <= ctrl.bypass;
        r      <= '0;
        bq     <= b;
        cnt    <= '0;
        phase  <= 1'b0;
        p      <= wide[WordBits-1:0];
      end else if (busy) begin
        if (bypass) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          r     <= r_next;
          phase <= ~phase;
          if (phase) begin
            bq  <= bq << 1;
            cnt <= cnt + 1'b1;
            if (cnt == cnt_t'(WordBits-1)) begin
              busy <= 1'b0;
              done <= 1'b1;
              p    <= r_next;
            end
          end
        end
      end
    end
  end
  logic unused;
  assign unused = ^{rdbl, sum_w[WordBits], dif_w[WordBits], wide[2*WordBits-1:WordBits]};
endmodule
`default_nettype wire

// ===== hdl/modular_exponentiation_unit.sv =====
// top level of the modular exponentiation unit: registers, square-and-multiply sequencer
// depends on mexp_pkg and mexp_mulmod
// One word is raised to the exponent register mod the modulus register and one result word
// returns per message. Exponent 0 or 1 passes the message through. Otherwise 32 squarings
// and one multiply per set exponent bit run on one shared bit-serial multiplier built as a
// row of 32 cells. Modulus zero wraps products to the word width. Results wait in an output
// register, and no new message is taken while a result is pending.
`default_nettype none
module modular_exponentiation_unit
  import mexp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_index,
  input  wire word_t cfg_data,
  input  wire logic  message_valid,
  output logic       message_ready,
  input  wire word_t message,
  output logic       result_valid,
  input  wire logic  result_ready,
  output word_t      result
);
  word_t    modulus, exponent, base, acc, ebits, msg;
  state_t   state, state_next;
  cnt_t     bit_cnt;
  mm_ctrl_t mctrl;
  word_t    ma, mb;
  logic     mbusy, mdone;
  word_t    mp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= word_t'(1);
      exponent <= word_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegModulus:  modulus  <= cfg_data;
        RegExponent: exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  mexp_mulmod u_mul (
    .clk(clk), .rst(rst), .ctrl(mctrl), .a(ma), .b(mb), .m(modulus),
    .busy(mbusy), .done(mdone), .p(mp)
  );

  assign message_ready = (state == ST_IDLE) && !result_valid;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and multiplier launch
  always_comb begin
    state_next   = state;
    mctrl.start  = 1'b0;
    mctrl.bypass = (modulus == '0);
    ma = acc;
    mb = acc;
    unique case (state)
      ST_IDLE:   if (message_valid && message_ready)
                   state_next = (exponent < word_t'(2)) ? ST_DONE : ST_REDUCE;
      ST_REDUCE: begin
        // base = (1 mod m) * msg, msg fed as the multiplier bits so it is fully reduced
        ma = acc; mb = msg;
        if (!mbusy && !mdone) mctrl.start = 1'b1;
        if (mdone) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (!mbusy && !mdone) mctrl.start = 1'b1;
        if (mdone) state_next = ebits[WordBits-1] ? ST_MULT :
                                (bit_cnt == cnt_t'(WordBits-1)) ? ST_DONE : ST_SQUARE;
      end
      ST_MULT: begin
        ma = acc; mb = base;
        if (!mbusy && !mdone) mctrl.start = 1'b1;
        if (mdone) state_next = (bit_cnt == cnt_t'(WordBits-1)) ? ST_DONE : ST_SQUARE;
      end
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (message_valid && message_ready) begin
          msg     <= message;
          ebits   <= exponent;
          bit_cnt <= '0;
          acc     <= (modulus == word_t'(1)) ? '0 : word_t'(1);
        end
        ST_REDUCE: if (mdone) base <= mp;
        ST_SQUARE: if (mdone) begin
          acc <= mp;
          if (!ebits[WordBits-1]) begin
            ebits   <= ebits << 1;
            bit_cnt <= bit_cnt + 1'b1;
          end
        end
        ST_MULT: if (mdone) begin
          acc     <= mp;
          ebits   <= ebits << 1;
          bit_cnt <= bit_cnt + 1'b1;
        end
        ST_DONE: begin
          result_valid <= 1'b1;
          result       <= (exponent < word_t'(2)) ? msg : acc;
        end
        default: ;
      endcase
    end
  end

  // no new word taken while a result is pending
  assert property (@(posedge clk) disable iff (rst) result_valid |-> !message_ready)
    else $error("message taken with result pending");
  // result only follows the done state
  assert property (@(posedge clk) disable iff (rst) $rose(result_valid) |-> $past(state == ST_DONE))
    else $error("result without completion");
  // multiplier never launched while busy
  assert property (@(posedge clk) disable iff (rst) mctrl.start |-> !mbusy)
    else $error("multiplier restarted while busy");
endmodule
`default_nettype wire
